FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bnpv_pkg.sv
// Shared types, widths and register codes for the Bezier nearest-point velocity block.
package bnpv_pkg;

	localparam int SAMPLES_DEF = 24;

	localparam int COORD_W   = 16;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int RAD_W     = 16;
	localparam int SPD_W     = 15;
	localparam int IDX_W     = 5;

	localparam int PC_W   = 28;
	localparam int DIFF_W = 29;
	localparam int SQ_W   = 56;
	localparam int DIST_W = 58;

	localparam int NDIFF_W = 17;
	localparam int NSQ_W   = 34;
	localparam int NSUM_W  = 36;

	localparam int DA_W   = 17;
	localparam int DB_W   = 18;
	localparam int SA_W   = 24;
	localparam int TS_W   = 26;
	localparam int T2_W   = 50;
	localparam int HALF_W = 25;
	localparam int QN_W   = 52;
	localparam int SP2_W  = 30;
	localparam int PP_W   = 55;
	localparam int R_W    = 82;
	localparam int ACC_W  = 90;
	localparam int RR_W   = 29;
	localparam int RR2_W  = 58;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START,
		REG_CONTROL,
		REG_END,
		REG_RADIUS,
		REG_SPEED
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PC_W-1:0]    pc_t;
	typedef logic [DIST_W-1:0]         dist_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic                      attached;
		logic [IDX_W-1:0]          nearest_sample;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic signed [COORD_W-1:0] vel_z;
	} out_item_t;

endpackage

FILE: rtl/bnpv_dist.sv
// Per-sample lanes: curve sample table, coordinate differences, squares and squared distance.
module bnpv_dist import bnpv_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  logic   clk,
	input  logic   adv,
	input  coord_t p0 [3],
	input  coord_t p1 [3],
	input  coord_t p2 [3],
	input  pc_t    qs [3],
	output dist_t  dist_out [SAMPLES+1]
);

	localparam int LANES = SAMPLES + 1;

	pc_t                c_q     [LANES][3];
	logic signed [DIFF_W-1:0] diff_s2 [LANES][3];
	logic [SQ_W-1:0]    sq_s3   [LANES][3];
	dist_t              dist_s4 [LANES];

	function automatic logic [SQ_W-1:0] sq_diff(input logic signed [DIFF_W-1:0] a);
		logic signed [2*DIFF_W-1:0] p;
		p = a * a;
		return p[SQ_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			for (int k = 0; k < 3; k++) begin
				c_q[i][k] <= PC_W'(((SAMPLES - i) * (SAMPLES - i)) * p0[k]
					+ (2 * i * (SAMPLES - i)) * p1[k] + (i * i) * p2[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				for (int k = 0; k < 3; k++) begin
					diff_s2[i][k] <= DIFF_W'(qs[k]) - DIFF_W'(c_q[i][k]);
					sq_s3[i][k]   <= sq_diff(diff_s2[i][k]);
				end
				dist_s4[i] <= DIST_W'(sq_s3[i][0]) + DIST_W'(sq_s3[i][1])
					+ DIST_W'(sq_s3[i][2]);
			end
		end
	end

	assign dist_out = dist_s4;

endmodule

FILE: rtl/bnpv_min.sv
// Registered minimum tree over the lane distances; ties go to the lower index.
module bnpv_min import bnpv_pkg::*; #(
	parameter int LANES = SAMPLES_DEF + 1,
	localparam int LVL  = $clog2(LANES)
) (
	input  logic           clk,
	input  logic           adv,
	input  dist_t          dist_in [LANES],
	output dist_t          best,
	output logic [LVL-1:0] best_idx
);

	localparam int LEAVES = 1 << LVL;
	localparam int NODES  = LEAVES - 1;
	localparam int ALL    = NODES + LEAVES;

	dist_t          node_dist_s [NODES];
	logic [LVL-1:0] node_idx_s  [NODES];
	dist_t          all_dist    [ALL];
	logic [LVL-1:0] all_idx     [ALL];

	always_comb begin
		for (int n = 0; n < NODES; n++) begin
			all_dist[n] = node_dist_s[n];
			all_idx[n]  = node_idx_s[n];
		end
		for (int j = 0; j < LEAVES; j++) begin
			all_dist[NODES+j] = (j < LANES) ? dist_in[(j < LANES) ? j : 0] : '1;
			all_idx[NODES+j]  = LVL'(j);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < NODES; n++) begin
				if (all_dist[2*n+2] < all_dist[2*n+1]) begin
					node_dist_s[n] <= all_dist[2*n+2];
					node_idx_s[n]  <= all_idx[2*n+2];
				end else begin
					node_dist_s[n] <= all_dist[2*n+1];
					node_idx_s[n]  <= all_idx[2*n+1];
				end
			end
		end
	end

	assign best     = node_dist_s[0];
	assign best_idx = node_idx_s[0];

endmodule

FILE: rtl/bnpv_norm.sv
// Digit-serial pipeline for round(speed * |t| / sqrt(qn)), one result bit per stage.
module bnpv_norm import bnpv_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [QN_W-1:0]  qn,
	input  logic [R_W-1:0]   r,
	output logic [SPD_W-1:0] mag
);

	logic signed [ACC_W-1:0] acc_s [SPD_W];
	logic signed [ACC_W-1:0] lin_s [SPD_W];
	logic [SPD_W-1:0]        mag_s [SPD_W];
	logic [QN_W-1:0]         qn_s  [SPD_W];
	logic [R_W-1:0]          r_s   [SPD_W];

	logic signed [ACC_W-1:0] src_acc [SPD_W];
	logic signed [ACC_W-1:0] src_lin [SPD_W];
	logic [SPD_W-1:0]        src_mag [SPD_W];
	logic [QN_W-1:0]         src_qn  [SPD_W];
	logic [R_W-1:0]          src_r   [SPD_W];
	logic signed [ACC_W-1:0] trial   [SPD_W];
	logic                    fits    [SPD_W];

	always_comb begin
		for (int st = 0; st < SPD_W; st++) begin
			if (st == 0) begin
				src_acc[st] = $signed(ACC_W'(qn));
				src_lin[st] = -$signed(ACC_W'(qn));
				src_mag[st] = '0;
				src_qn[st]  = qn;
				src_r[st]   = r;
			end else begin
				src_acc[st] = acc_s[st-1];
				src_lin[st] = lin_s[st-1];
				src_mag[st] = mag_s[st-1];
				src_qn[st]  = qn_s[st-1];
				src_r[st]   = r_s[st-1];
			end
			trial[st] = src_acc[st] + (src_lin[st] <<< (SPD_W - st + 1))
				+ $signed(ACC_W'(src_qn[st]) << (2 * (SPD_W - st)));
			fits[st]  = trial[st] <= $signed(ACC_W'(src_r[st]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int st = 0; st < SPD_W; st++) begin
				qn_s[st] <= src_qn[st];
				r_s[st]  <= src_r[st];
				if (fits[st]) begin
					acc_s[st] <= trial[st];
					lin_s[st] <= src_lin[st] + $signed(ACC_W'(src_qn[st]) << (SPD_W - st));
					mag_s[st] <= src_mag[st] | (SPD_W'(1) << (SPD_W - 1 - st));
				end else begin
					acc_s[st] <= src_acc[st];
					lin_s[st] <= src_lin[st];
					mag_s[st] <= src_mag[st];
				end
			end
		end
	end

	assign mag = mag_s[SPD_W-1];

endmodule

FILE: rtl/bezier_nearest_point_velocity_top.sv
// Throughput: one transaction per cycle while pos_stall is low; every stage of the lane,
// tree and norm pipeline takes a new point each cycle unless the skid register is full.
// A stalled result parks one transaction in a skid register; pos_stall rises only then.
// Reset clears the configuration registers, the pipeline valid bits and the output and skid valid bits.
module bezier_nearest_point_velocity_top import bnpv_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pos_valid,
	output logic                 pos_stall,
	input  in_item_t             pos,
	output logic                 res_valid,
	input  logic                 res_stall,
	output out_item_t            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LANES   = SAMPLES + 1;
	localparam int LVL     = $clog2(LANES);
	localparam int S2      = SAMPLES * SAMPLES;
	localparam int NEG_LEN = LVL + 4;
	localparam int LAST    = LVL + 8 + SPD_W;

	typedef struct packed {
		logic             attached;
		logic             neg;
		logic [2:0]       ts_neg;
		logic [IDX_W-1:0] idx;
	} side_t;

	logic [CFG_W-1:0] start_q, control_q, end_q;
	logic [RAD_W-1:0] radius_q;
	logic [SPD_W-1:0] speed_q;

	coord_t p0 [3];
	coord_t p1 [3];
	coord_t p2 [3];
	coord_t q_in [3];

	logic signed [SA_W-1:0] sa_q [3];
	logic signed [DB_W-1:0] db_q [3];
	logic [RR_W-1:0]        rr_q;
	logic [RR2_W-1:0]       rr2_q;
	logic [SP2_W-1:0]       sp2_q;

	logic adv;
	logic vld_s [1:LAST];

	pc_t                       qs_s1    [3];
	logic signed [NDIFF_W-1:0] diff0_s1 [3];
	logic signed [NDIFF_W-1:0] diff2_s1 [3];
	logic [NSQ_W-1:0]          nsq0_s2  [3];
	logic [NSQ_W-1:0]          nsq2_s2  [3];
	logic                      neg_s3;
	logic                      neg_dl   [NEG_LEN];

	dist_t          lane_dist [LANES];
	dist_t          best_dist;
	logic [LVL-1:0] best_idx;

	logic signed [TS_W-1:0] ts_t1 [3];
	logic                   rad_t1;
	logic [LVL-1:0]         idx_t1;
	logic [T2_W-1:0]        t2_t2 [3];
	logic [2:0]             tsneg_t2;
	logic                   rad_t2;
	logic [LVL-1:0]         idx_t2;
	logic [QN_W-1:0]        qn_t3;
	logic [PP_W-1:0]        pph_t3 [3];
	logic [PP_W-1:0]        ppl_t3 [3];
	logic [2:0]             tsneg_t3;
	logic                   rad_t3;
	logic [LVL-1:0]         idx_t3;
	logic [QN_W-1:0]        qn_t4;
	logic [R_W-1:0]         r_t4 [3];
	side_t                  side_t4;
	side_t                  side_dl [SPD_W];

	logic [SPD_W-1:0] mag_x, mag_y, mag_z;
	logic [SPD_W-1:0] mag [3];
	coord_t           vel [3];
	out_item_t        res_next;
	out_item_t        skid_q;
	logic             skid_valid_q;
	logic             incoming;

	function automatic logic [NSQ_W-1:0] sq_near(input logic signed [NDIFF_W-1:0] a);
		logic signed [2*NDIFF_W-1:0] p;
		p = a * a;
		return p[NSQ_W-1:0];
	endfunction

	function automatic logic [T2_W-1:0] sq_ts(input logic signed [TS_W-1:0] a);
		logic signed [2*TS_W-1:0] p;
		p = a * a;
		return p[T2_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			control_q <= '0;
			end_q     <= '0;
			radius_q  <= '0;
			speed_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START:   start_q   <= cfg_data;
				REG_CONTROL: control_q <= cfg_data;
				REG_END:     end_q     <= cfg_data;
				REG_RADIUS:  radius_q  <= cfg_data[RAD_W-1:0];
				REG_SPEED:   speed_q   <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p0[k] = $signed(start_q[COORD_W*k +: COORD_W]);
			p1[k] = $signed(control_q[COORD_W*k +: COORD_W]);
			p2[k] = $signed(end_q[COORD_W*k +: COORD_W]);
		end
	end

	assign q_in[0] = pos.pos_x;
	assign q_in[1] = pos.pos_y;
	assign q_in[2] = pos.pos_z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sa_q[k] <= SA_W'(SAMPLES * (DA_W'(p1[k]) - DA_W'(p0[k])));
			db_q[k] <= DB_W'(p2[k]) - (DB_W'(p1[k]) <<< 1) + DB_W'(p0[k]);
		end
		rr_q  <= RR_W'(32'(radius_q) * 32'(S2));
		rr2_q <= rr_q * rr_q;
		sp2_q <= speed_q * speed_q;
	end

	assign adv       = !skid_valid_q;
	assign pos_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= LAST; n++) vld_s[n] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= pos_valid;
			for (int n = 2; n <= LAST; n++) vld_s[n] <= vld_s[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				qs_s1[k]    <= PC_W'(q_in[k] * S2);
				diff0_s1[k] <= NDIFF_W'(q_in[k]) - NDIFF_W'(p0[k]);
				diff2_s1[k] <= NDIFF_W'(q_in[k]) - NDIFF_W'(p2[k]);
				nsq0_s2[k]  <= sq_near(diff0_s1[k]);
				nsq2_s2[k]  <= sq_near(diff2_s1[k]);
			end
			neg_s3 <= (NSUM_W'(nsq0_s2[0]) + NSUM_W'(nsq0_s2[1]) + NSUM_W'(nsq0_s2[2]))
				> (NSUM_W'(nsq2_s2[0]) + NSUM_W'(nsq2_s2[1]) + NSUM_W'(nsq2_s2[2]));
			neg_dl[0] <= neg_s3;
			for (int n = 1; n < NEG_LEN; n++) neg_dl[n] <= neg_dl[n-1];
		end
	end

	bnpv_dist #(
		.SAMPLES(SAMPLES)
	) u_dist (
		.clk      (clk),
		.adv      (adv),
		.p0       (p0),
		.p1       (p1),
		.p2       (p2),
		.qs       (qs_s1),
		.dist_out (lane_dist)
	);

	bnpv_min #(
		.LANES(LANES)
	) u_min (
		.clk      (clk),
		.adv      (adv),
		.dist_in  (lane_dist),
		.best     (best_dist),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				ts_t1[k] <= TS_W'(sa_q[k])
					+ TS_W'(db_q[k]) * TS_W'($signed({1'b0, best_idx}));
				t2_t2[k]    <= sq_ts(ts_t1[k]);
				tsneg_t2[k] <= ts_t1[k][TS_W-1];
				pph_t3[k]   <= sp2_q * t2_t2[k][T2_W-1:HALF_W];
				ppl_t3[k]   <= sp2_q * t2_t2[k][HALF_W-1:0];
				r_t4[k]     <= ((R_W'(pph_t3[k]) << HALF_W) + R_W'(ppl_t3[k])) << 2;
			end
			rad_t1   <= best_dist <= rr2_q;
			idx_t1   <= best_idx;
			rad_t2   <= rad_t1;
			idx_t2   <= idx_t1;
			qn_t3    <= QN_W'(t2_t2[0]) + QN_W'(t2_t2[1]) + QN_W'(t2_t2[2]);
			tsneg_t3 <= tsneg_t2;
			rad_t3   <= rad_t2;
			idx_t3   <= idx_t2;
			qn_t4    <= qn_t3;
			side_t4  <= '{attached: rad_t3 && (qn_t3 != '0), neg: neg_dl[NEG_LEN-1],
				ts_neg: tsneg_t3, idx: IDX_W'(idx_t3)};
			side_dl[0] <= side_t4;
			for (int n = 1; n < SPD_W; n++) side_dl[n] <= side_dl[n-1];
		end
	end

	bnpv_norm u_norm_x (.clk(clk), .adv(adv), .qn(qn_t4), .r(r_t4[0]), .mag(mag_x));
	bnpv_norm u_norm_y (.clk(clk), .adv(adv), .qn(qn_t4), .r(r_t4[1]), .mag(mag_y));
	bnpv_norm u_norm_z (.clk(clk), .adv(adv), .qn(qn_t4), .r(r_t4[2]), .mag(mag_z));

	assign mag[0] = mag_x;
	assign mag[1] = mag_y;
	assign mag[2] = mag_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!side_dl[SPD_W-1].attached) begin
				vel[k] = '0;
			end else if (side_dl[SPD_W-1].ts_neg[k] ^ side_dl[SPD_W-1].neg) begin
				vel[k] = -$signed({1'b0, mag[k]});
			end else begin
				vel[k] = $signed({1'b0, mag[k]});
			end
		end
		res_next.attached       = side_dl[SPD_W-1].attached;
		res_next.nearest_sample = side_dl[SPD_W-1].idx;
		res_next.vel_x          = vel[0];
		res_next.vel_y          = vel[1];
		res_next.vel_z          = vel[2];
	end

	assign incoming = vld_s[LAST] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid || !res_stall) begin
			res_valid    <= skid_valid_q || incoming;
			skid_valid_q <= 1'b0;
		end else if (incoming) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid || !res_stall) begin
			res <= skid_valid_q ? skid_q : res_next;
		end else if (incoming) begin
			skid_q <= res_next;
		end
	end

endmodule

FILE: rtl/bnpv_checker.sv
// Port-level checker for the Bezier nearest-point velocity block and its bind.
`include "assert_macros.svh"

module bnpv_checker import bnpv_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input out_item_t res,
	input logic      pos_stall
);

	`ASSERT_CLK(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(res), "result transaction changed while stalled")
	`ASSERT_CLK(a_detached_zero, clk, arst_n, res_valid && !res.attached |-> res.vel_x == '0 && res.vel_y == '0 && res.vel_z == '0, "detached result carries a velocity")
	`ASSERT_CLK(a_index_range, clk, arst_n, res_valid |-> (SAMPLES > 31) || (res.nearest_sample <= SAMPLES), "nearest sample beyond curve end")
	`ASSERT_ALWAYS(a_reset_empty, clk, $rose(arst_n) |-> !res_valid && !pos_stall, "pipeline not empty after reset")

endmodule

bind bezier_nearest_point_velocity_top bnpv_checker #(.SAMPLES(SAMPLES)) u_bnpv_checker (.*);
